// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define AST_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define AST_ALW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/ebml_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// EBML encoder package
// Types and constants shared by the EBML element encoder.
// ----------------------------------------------------------------------------
package ebml_enc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_action;

    localparam int MaxBytes = 13;
    localparam int CntW = 4;

    localparam t_action ACT_HEADER = 2'd0;
    localparam t_action ACT_UINT   = 2'd1;
    localparam t_action ACT_FLOAT  = 2'd2;
    localparam t_action ACT_RAW    = 2'd3;

    localparam logic [31:0] SZ_LIM1 = 32'h0000_007f;
    localparam logic [31:0] SZ_LIM2 = 32'h0000_3fff;
    localparam logic [31:0] SZ_LIM3 = 32'h001f_ffff;
    localparam logic [31:0] SZ_LIM4 = 32'h0fff_ffff;

    localparam t_byte MARK1 = 8'h80;
    localparam t_byte MARK2 = 8'h40;
    localparam t_byte MARK3 = 8'h20;
    localparam t_byte MARK4 = 8'h10;
    localparam t_byte MARK5 = 8'h08;

endpackage

// ===== sv/ebml_element_encoder.sv =====
// ----------------------------------------------------------------------------
// EBML element encoder
// Turns one element piece per input beat into a big-endian byte stream.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata                           tuser       tlast
//  s_axis    in   element_id[31:0], value[95:32]  action[1:0] -
//  m_axis    out  out_byte[7:0]                   -           last
//
// An item is held in the input register, encoded combinationally into a
// 13-byte shift register and sent out at one byte per cycle while m_axis_tready is high, 1 to 13 beats.
// The next item is loaded as the last byte of the previous one leaves, so
// items follow without gaps. The output byte comes straight from a register.
// Reset is synchronous, active low, and empties both stages.
// Back-pressure on m_axis holds the shift register and, once the input
// register is full, deasserts s_axis_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebml_element_encoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [95:0]           s_axis_tdata,  // element_id[31:0], value[95:32]
    input  ebml_enc_pkg::t_action s_axis_tuser,  // action[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output ebml_enc_pkg::t_byte   m_axis_tdata,  // out_byte[7:0]
    output logic                  m_axis_tlast
);
    import ebml_enc_pkg::*;

    t_action           r_act;
    logic [31:0]       r_id;
    logic [63:0]       r_val;
    logic              r_in_vld;
    logic              n_in_vld;

    t_byte             r_buf [MaxBytes];
    t_byte             n_buf [MaxBytes];
    logic [CntW-1:0]   r_cnt;
    logic [CntW-1:0]   n_cnt;

    logic              s_beat;
    logic              m_beat;
    logic              load;

    logic [2:0]        id_len;
    logic [2:0]        sz_len;
    logic [3:0]        pay_len;
    logic [31:0]       id_al;
    t_byte             sz_b  [8];
    t_byte             pay_b [8];
    logic [63:0]       val_al;
    logic [3:0]        u_len;
    logic [CntW-1:0]   enc_len;
    t_byte             enc_b [MaxBytes];

    assign m_beat        = m_axis_tvalid && m_axis_tready;
    assign load          = r_in_vld && ((r_cnt == '0) || (r_cnt == CntW'(1) && m_beat));
    assign s_axis_tready = !r_in_vld || load;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_buf[0];
    assign m_axis_tlast  = (r_cnt == CntW'(1));

    // Minimal byte count of the unsigned value, at least one.
    always_comb begin
        u_len = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if (r_val[8*i +: 8] != 8'h00) begin
                u_len = 4'(i + 1);
            end
        end
    end

    always_comb begin
        case (u_len)
            4'd1:    val_al = {r_val[7:0],  56'h0};
            4'd2:    val_al = {r_val[15:0], 48'h0};
            4'd3:    val_al = {r_val[23:0], 40'h0};
            4'd4:    val_al = {r_val[31:0], 32'h0};
            4'd5:    val_al = {r_val[39:0], 24'h0};
            4'd6:    val_al = {r_val[47:0], 16'h0};
            4'd7:    val_al = {r_val[55:0], 8'h0};
            default: val_al = r_val;
        endcase
    end

    always_comb begin
        if (r_id[31:24] != 8'h00) begin
            id_al = r_id;
        end else if (r_id[23:16] != 8'h00) begin
            id_al = {r_id[23:0], 8'h0};
        end else if (r_id[15:8] != 8'h00) begin
            id_al = {r_id[15:0], 16'h0};
        end else begin
            id_al = {r_id[7:0], 24'h0};
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sz_b[i]  = 8'h00;
            pay_b[i] = 8'h00;
        end
        if (r_id[31:24] != 8'h00) begin
            id_len = 3'd4;
        end else if (r_id[23:16] != 8'h00) begin
            id_len = 3'd3;
        end else if (r_id[15:8] != 8'h00) begin
            id_len = 3'd2;
        end else begin
            id_len = 3'd1;
        end
        sz_len  = 3'd1;
        pay_len = 4'd0;
        unique case (r_act)
            ACT_HEADER: begin
                if (r_val[31:0] < SZ_LIM1) begin
                    sz_b[0] = MARK1 | r_val[7:0];
                    sz_len  = 3'd1;
                end else if (r_val[31:0] < SZ_LIM2) begin
                    sz_b[0] = MARK2 | {2'b00, r_val[13:8]};
                    sz_b[1] = r_val[7:0];
                    sz_len  = 3'd2;
                end else if (r_val[31:0] < SZ_LIM3) begin
                    sz_b[0] = MARK3 | {3'b000, r_val[20:16]};
                    sz_b[1] = r_val[15:8];
                    sz_b[2] = r_val[7:0];
                    sz_len  = 3'd3;
                end else if (r_val[31:0] < SZ_LIM4) begin
                    sz_b[0] = MARK4 | {4'h0, r_val[27:24]};
                    sz_b[1] = r_val[23:16];
                    sz_b[2] = r_val[15:8];
                    sz_b[3] = r_val[7:0];
                    sz_len  = 3'd4;
                end else begin
                    sz_b[0] = MARK5;
                    sz_b[1] = r_val[31:24];
                    sz_b[2] = r_val[23:16];
                    sz_b[3] = r_val[15:8];
                    sz_b[4] = r_val[7:0];
                    sz_len  = 3'd5;
                end
            end
            ACT_UINT: begin
                sz_b[0] = MARK1 | {4'h0, u_len};
                for (int i = 0; i < 8; i++) begin
                    pay_b[i] = val_al[63 - 8*i -: 8];
                end
                pay_len = u_len;
            end
            ACT_FLOAT: begin
                sz_b[0] = MARK1 | 8'h04;
                for (int i = 0; i < 4; i++) begin
                    pay_b[i] = r_val[31 - 8*i -: 8];
                end
                pay_len = 4'd4;
            end
            ACT_RAW: begin
                id_len   = 3'd0;
                sz_len   = 3'd0;
                pay_b[0] = r_val[7:0];
                pay_len  = 4'd1;
            end
        endcase
    end

    assign enc_len = CntW'({1'b0, id_len}) + CntW'({1'b0, sz_len}) + pay_len;

    // Each output position picks from the ID, size or payload bytes.
    always_comb begin
        logic [3:0] j;
        logic [3:0] p;
        for (int k = 0; k < MaxBytes; k++) begin
            j = 4'(k) - {1'b0, id_len};
            p = j - {1'b0, sz_len};
            if (k < 4 && 4'(k) < {1'b0, id_len}) begin
                enc_b[k] = id_al[31 - 8*(k % 4) -: 8];
            end else if (j < {1'b0, sz_len}) begin
                enc_b[k] = sz_b[j[2:0]];
            end else begin
                enc_b[k] = pay_b[p[2:0]];
            end
        end
    end

    always_comb begin
        n_in_vld = r_in_vld;
        if (s_beat) begin
            n_in_vld = 1'b1;
        end else if (load) begin
            n_in_vld = 1'b0;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        for (int i = 0; i < MaxBytes; i++) begin
            n_buf[i] = r_buf[i];
        end
        if (load) begin
            n_cnt = enc_len;
            for (int i = 0; i < MaxBytes; i++) begin
                n_buf[i] = enc_b[i];
            end
        end else if (m_beat) begin
            n_cnt = r_cnt - CntW'(1);
            for (int i = 0; i < MaxBytes - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_buf[MaxBytes - 1] = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_in_vld <= n_in_vld;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_act <= s_axis_tuser;
            r_id  <= s_axis_tdata[31:0];
            r_val <= s_axis_tdata[95:32];
        end
        for (int i = 0; i < MaxBytes; i++) begin
            r_buf[i] <= n_buf[i];
        end
    end

    `AST_CHK(a_cnt_range, r_cnt <= CntW'(MaxBytes), "byte count out of range")
    `AST_CHK(a_load_len, load |-> (enc_len != '0 && enc_len <= CntW'(MaxBytes)), "bad item length")
    `AST_CHK(a_mid_beat, (m_beat && !m_axis_tlast) |=> m_axis_tvalid, "item cut short")
    `AST_CHK(a_drain, (m_beat && m_axis_tlast && !r_in_vld) |=> !m_axis_tvalid, "extra beat after last")
    `AST_ALW(a_rst_idle, !i_rst_n |=> (!m_axis_tvalid && s_axis_tready), "not idle after reset")

endmodule
